// ===== hdl/via_tmr_pkg.sv =====
// ============================================================================
// via_tmr_pkg
// Shared types, register map codes and flag masks of the VIA timer block.
// ============================================================================
`default_nettype none

package via_tmr_pkg;

    // Register map, indexed by reg_select
    localparam logic [3:0] RS_ORB  = 4'd0;
    localparam logic [3:0] RS_ORA  = 4'd1;
    localparam logic [3:0] RS_DDRB = 4'd2;
    localparam logic [3:0] RS_DDRA = 4'd3;
    localparam logic [3:0] RS_T1CL = 4'd4;
    localparam logic [3:0] RS_T1CH = 4'd5;
    localparam logic [3:0] RS_T1LL = 4'd6;
    localparam logic [3:0] RS_T1LH = 4'd7;
    localparam logic [3:0] RS_T2CL = 4'd8;
    localparam logic [3:0] RS_T2CH = 4'd9;
    localparam logic [3:0] RS_ACR  = 4'd11;
    localparam logic [3:0] RS_IFR  = 4'd13;
    localparam logic [3:0] RS_IER  = 4'd14;

    // Flag and control bit masks
    localparam logic [7:0] IFR_T1       = 8'h40;
    localparam logic [7:0] IFR_T2       = 8'h20;
    localparam logic [7:0] IFR_ANY      = 8'h80;
    localparam logic [7:0] IRQ_SRC_MASK = 8'h7f;
    localparam logic [7:0] ACR_T1_CONT  = 8'h40;
    localparam logic [7:0] IER_SET      = 8'h80;
    localparam logic [7:0] IER_RESET    = 8'h80;

    typedef logic [15:0][7:0] t_rf;

    typedef struct packed {
        logic       chip_select;
        logic       chip_select_low;
        logic       write_enable;
        logic [3:0] reg_select;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] port_a_value;
        logic [7:0] port_b_value;
    } t_result;

    // Timer state after a counting step
    typedef struct packed {
        logic [15:0] t1_cnt;
        logic [15:0] t2_cnt;
        logic [7:0]  ifr;
    } t_tick;

    // Drop the given flags; drop the summary bit too when no source is left
    function automatic logic [7:0] clear_flag(input logic [7:0] ifr, input logic [7:0] mask);
        logic [7:0] f;
        f = ifr & ~mask;
        if ((f & IRQ_SRC_MASK) == 8'h00) begin
            f = 8'h00;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/via_tmr_if.sv =====
// ============================================================================
// via_tmr_if
// Valid/ready channels carrying bus cycles in and register results out.
// ============================================================================
`default_nettype none

interface via_tmr_in_if;
    logic       valid;
    logic       ready;
    logic       chip_select;
    logic       chip_select_low;
    logic       write_enable;
    logic [3:0] reg_select;
    logic [7:0] write_data;

    modport source (output valid, output chip_select, output chip_select_low,
                    output write_enable, output reg_select, output write_data,
                    input ready);
    modport sink   (input valid, input chip_select, input chip_select_low,
                    input write_enable, input reg_select, input write_data,
                    output ready);
endinterface

interface via_tmr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_value;
    logic [7:0] port_b_value;

    modport source (output valid, output read_data, output irq,
                    output port_a_value, output port_b_value, input ready);
    modport sink   (input valid, input read_data, input irq,
                    input port_a_value, input port_b_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/via_timer_register_block_top.sv =====
// ============================================================================
// via_timer_register_block_top
// 6522-style timer and port register block, one bus cycle per beat.
// ============================================================================
//
//   channel | dir | beat carries                                         
//   --------+-----+---------------------------------------------------------
//   i_in    | in  | chip_select, chip_select_low, write_enable,
//           |     | reg_select, write_data (one bus clock cycle)
//   o_out   | out | read_data, irq, port_a_value, port_b_value
//
// Every beat goes through an input register, then the tick and access
// logic, then the result register, which loads when empty or drained; one
// beat per clock is sustained while o_out takes every result.
// The input register can still take a beat while a result waits on o_out;
// i_in.ready drops only once both registers are full.
// Synchronous reset clears the register file (IER reads 0x80) and both
// port latches, and empties both pipeline registers.
// ============================================================================
`default_nettype none

module via_timer_register_block_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    via_tmr_in_if.sink           i_in,
    via_tmr_out_if.source        o_out
);
    import via_tmr_pkg::*;

    // Register file after reset: all zero except the enable register
    localparam t_rf RF_RESET = t_rf'({120'h0, IER_RESET} << (8 * RS_IER));

    // Input stage
    logic       r_in_vld;
    t_item      r_in;

    // Result stage
    logic       r_out_vld;
    t_result    r_out;

    // Architectural state
    t_rf        r_rf;
    logic [7:0] r_port_a;
    logic [7:0] r_port_b;

    // Next values out of the datapath
    t_tick      n_tick;
    t_rf        n_rf;
    logic [7:0] n_port_a;
    logic [7:0] n_port_b;
    t_result    n_result;

    logic       advance;
    logic       in_ready;

    // The result stage can load when empty or being drained this cycle
    assign advance  = !r_out_vld || o_out.ready;
    assign in_ready = !r_in_vld || advance;

    assign i_in.ready = in_ready;

    via_tmr_tick u_tick (
        .i_rf   (r_rf),
        .o_tick (n_tick)
    );

    via_tmr_acc u_acc (
        .i_item   (r_in),
        .i_rf     (r_rf),
        .i_tick   (n_tick),
        .i_port_a (r_port_a),
        .i_port_b (r_port_b),
        .o_rf     (n_rf),
        .o_port_a (n_port_a),
        .o_port_b (n_port_b),
        .o_result (n_result)
    );

    // Capture a beat whenever the input register is free or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_in.chip_select     <= i_in.chip_select;
            r_in.chip_select_low <= i_in.chip_select_low;
            r_in.write_enable    <= i_in.write_enable;
            r_in.reg_select      <= i_in.reg_select;
            r_in.write_data      <= i_in.write_data;
        end
    end

    // Advance: commit the cycle's state and present its result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld        <= 1'b0;
            r_rf             <= RF_RESET;
            r_port_a         <= 8'h00;
            r_port_b         <= 8'h00;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_rf     <= n_rf;
                r_port_a <= n_port_a;
                r_port_b <= n_port_b;
            end
        end
    end

    // Hold the result while o_out stalls
    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.read_data    = r_out.read_data;
    assign o_out.irq          = r_out.irq;
    assign o_out.port_a_value = r_out.port_a_value;
    assign o_out.port_b_value = r_out.port_b_value;

endmodule

`default_nettype wire

// ===== hdl/via_tmr_tick.sv =====
// ============================================================================
// via_tmr_tick
// Timer counting step: decrement, reload and flag raising.
// ============================================================================
`default_nettype none

module via_tmr_tick (
    input  via_tmr_pkg::t_rf   i_rf,
    output via_tmr_pkg::t_tick o_tick
);
    import via_tmr_pkg::*;

    logic [15:0] t1_dec;
    logic [15:0] t2_dec;
    logic        t1_zero;
    logic        t2_zero;
    logic        t1_cont;
    logic [7:0]  ifr;

    always_comb begin
        t1_dec  = {i_rf[RS_T1CH], i_rf[RS_T1CL]} - 16'd1;
        t2_dec  = {i_rf[RS_T2CH], i_rf[RS_T2CL]} - 16'd1;
        t1_zero = (t1_dec == 16'd0);
        t2_zero = (t2_dec == 16'd0);
        t1_cont = |(i_rf[RS_ACR] & ACR_T1_CONT);

        ifr = i_rf[RS_IFR];
        // one-shot mode raises only on a clear flag
        if (t1_zero && (t1_cont || !(|(ifr & IFR_T1)))) begin
            ifr = ifr | IFR_T1 | IFR_ANY;
        end
        if (t2_zero && !(|(ifr & IFR_T2))) begin
            ifr = ifr | IFR_T2 | IFR_ANY;
        end

        o_tick.t1_cnt = (t1_zero && t1_cont) ? {i_rf[RS_T1LH], i_rf[RS_T1LL]} : t1_dec;
        o_tick.t2_cnt = t2_dec;
        o_tick.ifr    = ifr;
    end

endmodule

`default_nettype wire

// ===== hdl/via_tmr_acc.sv =====
// ============================================================================
// via_tmr_acc
// Register access of one bus cycle on top of the ticked timer state.
// ============================================================================
`default_nettype none

module via_tmr_acc (
    input  via_tmr_pkg::t_item   i_item,
    input  via_tmr_pkg::t_rf     i_rf,
    input  via_tmr_pkg::t_tick   i_tick,
    input  logic [7:0]           i_port_a,
    input  logic [7:0]           i_port_b,
    output via_tmr_pkg::t_rf     o_rf,
    output logic [7:0]           o_port_a,
    output logic [7:0]           o_port_b,
    output via_tmr_pkg::t_result o_result
);
    import via_tmr_pkg::*;

    t_rf        rf;
    logic [7:0] pa;
    logic [7:0] pb;
    logic [7:0] rd;
    logic [7:0] d;
    logic [7:0] ier;
    logic       sel;

    always_comb begin
        rf = i_rf;
        rf[RS_T1CL] = i_tick.t1_cnt[7:0];
        rf[RS_T1CH] = i_tick.t1_cnt[15:8];
        rf[RS_T2CL] = i_tick.t2_cnt[7:0];
        rf[RS_T2CH] = i_tick.t2_cnt[15:8];
        rf[RS_IFR]  = i_tick.ifr;
        pa  = i_port_a;
        pb  = i_port_b;
        rd  = 8'h00;
        d   = i_item.write_data;
        ier = 8'h00;
        sel = i_item.chip_select && !i_item.chip_select_low;

        if (sel && i_item.write_enable) begin
            unique case (i_item.reg_select)
                RS_ORB: begin
                    rf[RS_ORB] = d;
                    pb = (d & rf[RS_DDRB]) | (pb & ~rf[RS_DDRB]);
                end
                RS_ORA: begin
                    rf[RS_ORA] = d;
                    pa = (d & rf[RS_DDRA]) | (pa & ~rf[RS_DDRA]);
                end
                RS_T1CL: begin
                    rf[RS_T1LL] = d;
                end
                RS_T1CH: begin
                    // latch high, then load the counter from the whole latch
                    rf[RS_T1LH] = d;
                    rf[RS_T1CL] = rf[RS_T1LL];
                    rf[RS_T1CH] = d;
                    rf[RS_IFR]  = clear_flag(rf[RS_IFR], IFR_T1);
                end
                RS_T2CH: begin
                    rf[RS_T2CH] = d;
                    rf[RS_IFR]  = clear_flag(rf[RS_IFR], IFR_T2);
                end
                RS_IER: begin
                    if (|(d & IER_SET)) begin
                        ier = rf[RS_IER] | (d & IRQ_SRC_MASK);
                    end else begin
                        ier = rf[RS_IER] & ~(d & IRQ_SRC_MASK);
                    end
                    rf[RS_IER] = ier | IER_SET;
                end
                default: begin
                    rf[i_item.reg_select] = d;
                end
            endcase
        end else if (sel) begin
            unique case (i_item.reg_select)
                RS_ORB: begin
                    rf[RS_ORB] = (pb & ~rf[RS_DDRB]) | (rf[RS_ORB] & rf[RS_DDRB]);
                end
                RS_ORA: begin
                    rf[RS_ORA] = (pa & ~rf[RS_DDRA]) | (rf[RS_ORA] & rf[RS_DDRA]);
                end
                RS_T1CL: begin
                    rf[RS_IFR] = clear_flag(rf[RS_IFR], IFR_T1);
                end
                RS_T2CL: begin
                    rf[RS_IFR] = clear_flag(rf[RS_IFR], IFR_T2);
                end
                default: begin
                end
            endcase
            rd = rf[i_item.reg_select];
        end

        o_rf                  = rf;
        o_port_a              = pa;
        o_port_b              = pb;
        o_result.read_data    = rd;
        o_result.irq          = |(rf[RS_IFR] & rf[RS_IER] & IRQ_SRC_MASK);
        o_result.port_a_value = pa;
        o_result.port_b_value = pb;
    end

endmodule

`default_nettype wire

// ===== hdl/via_tmr_chk.sv =====
// ============================================================================
// via_tmr_chk
// Port-level checks of the VIA timer block, bound to the top level.
// ============================================================================
`default_nettype none

module via_tmr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_read_data,
    input logic       i_irq,
    input logic [7:0] i_port_a_value,
    input logic [7:0] i_port_b_value
);

    // An empty result stage always frees the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result stage");

    // A fresh result comes from a beat accepted on i_in via the input register
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without an accepted beat");

    // Reset empties the result stage
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_read_data) &&
            $stable(i_irq) && $stable(i_port_a_value) && $stable(i_port_b_value))
        else $error("stalled result changed");

endmodule

bind via_timer_register_block_top via_tmr_chk u_via_tmr_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_read_data    (o_out.read_data),
    .i_irq          (o_out.irq),
    .i_port_a_value (o_out.port_a_value),
    .i_port_b_value (o_out.port_b_value)
);

`default_nettype wire
